@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SMD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SMD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `SMD_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

@@ rtl/smd_pkg.sv @@
// types and constants of the sorted merge and duplicate removal unit
package smd_pkg;

   localparam int LIST_DEPTH_DEF  = 32;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DATA_W          = 32;
   localparam int OP_W            = 2;

   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_START  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_CMP   = 4'b0100,
      S_FLUSH = 4'b1000
   } smd_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } smd_mem_ctl_type;

endpackage

@@ rtl/smd_list_mem.sv @@
// list store: one write port, one registered read port
module smd_list_mem #(
   parameter int LIST_DEPTH  = smd_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = smd_pkg::VALUE_WIDTH_DEF,
   localparam int ADDR_W     = ($clog2(LIST_DEPTH) > 0) ? $clog2(LIST_DEPTH) : 1
) (
   input  logic                          clock,
   input  smd_pkg::smd_mem_ctl_type      ctl,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic signed [VALUE_WIDTH-1:0] rd_data
);

   logic signed [VALUE_WIDTH-1:0] mem [LIST_DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sorted_merge_dedup_unit.sv @@
// top level of the sorted merge and duplicate removal unit
// Values are loaded into list A (tuser 0) or list B (tuser 1), one item per cycle, up to
// LIST_DEPTH entries each; further loads are dropped. A start item (tuser 2) merges both
// ascending lists, smallest first with list A winning ties, and returns each distinct value
// once; the final result carries tlast, and two empty lists give one zero result with tlast
// and tuser set. Each list sits in its own memory with one registered read port, so every
// element taken by the merge passes through a read state and then a compare state, and a
// compare that must emit a result waits while the output is stalled; no item is accepted
// until its last result has entered the output register. Both counts return to zero after
// each merge.
`include "assert_macros.svh"

module sorted_merge_dedup_unit #(
   parameter int LIST_DEPTH  = smd_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = smd_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [smd_pkg::DATA_W-1:0] req_tdata,  // value
   input  logic [smd_pkg::OP_W-1:0]   req_tuser,  // opcode
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [smd_pkg::DATA_W-1:0] rsp_tdata,  // out_value
   output logic                       rsp_tlast,  // is_last
   output logic [0:0]                 rsp_tuser   // empty_res
);

   localparam int ADDR_W = ($clog2(LIST_DEPTH) > 0) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

   smd_pkg::smd_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic pend_valid_ff, pend_valid_in, pend_empty_ff, pend_empty_in;
   logic signed [VALUE_WIDTH-1:0] pend_val_ff, pend_val_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_empty_ff, rsp_empty_in;
   logic [smd_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;

   smd_pkg::smd_mem_ctl_type ctl_a, ctl_b;
   logic signed [VALUE_WIDTH-1:0] wr_val, rd_a, rd_b, taken;
   logic accept, out_free, a_avail, b_avail, take_b, distinct, need_out, advance;
   logic [CNT_W-1:0] ia_nx, ib_nx;

   assign req_tready = (state_ff == smd_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_val     = VALUE_WIDTH'($signed(req_tdata));

   assign a_avail  = (ia_ff < cnt_a_ff);
   assign b_avail  = (ib_ff < cnt_b_ff);
   assign take_b   = !a_avail || (b_avail && (rd_a > rd_b));
   assign taken    = take_b ? rd_b : rd_a;
   assign distinct = !pend_valid_ff || (taken != pend_val_ff);
   assign need_out = pend_valid_ff && distinct;
   assign advance  = !need_out || out_free;
   assign ia_nx    = take_b ? ia_ff : ia_ff + CNT_W'(1);
   assign ib_nx    = take_b ? ib_ff + CNT_W'(1) : ib_ff;

   always_comb begin
      ctl_a.wr_en = accept && (req_tuser == smd_pkg::OP_LOAD_A) && (cnt_a_ff < FULL);
      ctl_b.wr_en = accept && (req_tuser == smd_pkg::OP_LOAD_B) && (cnt_b_ff < FULL);
      ctl_a.rd_en = (state_ff == smd_pkg::S_READ) && a_avail;
      ctl_b.rd_en = (state_ff == smd_pkg::S_READ) && b_avail;
   end

   smd_list_mem #(.LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_list_a (
      .clock   (clock),
      .ctl     (ctl_a),
      .wr_addr (cnt_a_ff[ADDR_W-1:0]),
      .wr_data (wr_val),
      .rd_addr (ia_ff[ADDR_W-1:0]),
      .rd_data (rd_a)
   );

   smd_list_mem #(.LIST_DEPTH(LIST_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_list_b (
      .clock   (clock),
      .ctl     (ctl_b),
      .wr_addr (cnt_b_ff[ADDR_W-1:0]),
      .wr_data (wr_val),
      .rd_addr (ib_ff[ADDR_W-1:0]),
      .rd_data (rd_b)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      pend_valid_in = pend_valid_ff;
      pend_empty_in = pend_empty_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         smd_pkg::S_IDLE: begin
            if (ctl_a.wr_en) begin
               cnt_a_in = cnt_a_ff + CNT_W'(1);
            end
            if (ctl_b.wr_en) begin
               cnt_b_in = cnt_b_ff + CNT_W'(1);
            end
            if (accept && (req_tuser == smd_pkg::OP_START)) begin
               ia_in = '0;
               ib_in = '0;
               if ((cnt_a_ff == '0) && (cnt_b_ff == '0)) begin
                  pend_valid_in = 1'b1;
                  pend_empty_in = 1'b1;
                  pend_val_in   = '0;
                  state_in      = smd_pkg::S_FLUSH;
               end else begin
                  pend_valid_in = 1'b0;
                  pend_empty_in = 1'b0;
                  state_in      = smd_pkg::S_READ;
               end
            end
         end
         smd_pkg::S_READ: begin
            state_in = smd_pkg::S_CMP;
         end
         smd_pkg::S_CMP: begin
            if (advance) begin
               ia_in = ia_nx;
               ib_in = ib_nx;
               if (distinct) begin
                  pend_valid_in = 1'b1;
                  pend_val_in   = taken;
               end
               if (need_out) begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = 1'b0;
                  rsp_data_in  = smd_pkg::DATA_W'(pend_val_ff);
               end
               if ((ia_nx < cnt_a_ff) || (ib_nx < cnt_b_ff)) begin
                  state_in = smd_pkg::S_READ;
               end else begin
                  state_in = smd_pkg::S_FLUSH;
               end
            end
         end
         smd_pkg::S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = pend_empty_ff;
               rsp_data_in   = smd_pkg::DATA_W'(pend_val_ff);
               pend_valid_in = 1'b0;
               cnt_a_in      = '0;
               cnt_b_in      = '0;
               state_in      = smd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= smd_pkg::S_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         ia_ff         <= '0;
         ib_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_empty_ff <= pend_empty_in;
      pend_val_ff   <= pend_val_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_empty_ff;

   // empty result only ever closes a run
   `SMD_ASSERT(a_empty_is_last, clock, reset, (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast,
      "empty result without last")
   // fill counts stay within the store
   `SMD_ASSERT(a_count_bound, clock, reset, (cnt_a_ff <= FULL) && (cnt_b_ff <= FULL),
      "list count beyond depth")
   // a compare step always has a head to take
   `SMD_ASSERT_NEVER(a_cmp_no_head, clock, reset,
      (state_ff == smd_pkg::S_CMP) && !a_avail && !b_avail, "compare with both lists spent")
   // a finished merge leaves both lists empty
   `SMD_ASSERT(a_flush_clears, clock, reset,
      ((state_ff == smd_pkg::S_FLUSH) && out_free) |=> ((cnt_a_ff == '0) && (cnt_b_ff == '0)),
      "counts not cleared after merge")

endmodule
